// ----- hw/rtl/acvr_pkg.sv -----
`timescale 1ns / 1ps

package acvr_pkg;

  // Default width of the internal position counters.
  localparam int unsigned PosBitsDefault = 32;

  // Width of the coordinates on the result stream.
  localparam int unsigned CoordBits = 32;

  // Width of the start coordinates on the column stream.
  localparam int unsigned StartBits = 31;

  // Depth of the result queue and width of its pointers.
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrBits = $clog2(ResDepth);
  localparam int unsigned ResCntBits = $clog2(ResDepth + 1);

  // Base characters that the caller looks at.
  localparam logic [7:0] CharGap   = 8'h2D;  // '-'
  localparam logic [7:0] CharNUp   = 8'h4E;  // 'N'
  localparam logic [7:0] CharNLow  = 8'h6E;  // 'n'

  // Match-line symbols.
  typedef enum logic [1:0] {
    MAP_MATCH    = 2'd0,  // '|'
    MAP_GAP      = 2'd1,  // ' '
    MAP_MISMATCH = 2'd2,  // '.'
    MAP_OTHER    = 2'd3
  } map_code_e;

  // Variant kinds on the result stream.
  typedef enum logic [2:0] {
    VAR_REFCALL = 3'd0,
    VAR_INS     = 3'd1,
    VAR_DEL     = 3'd2,
    VAR_NTGT    = 3'd3,
    VAR_NQRY    = 3'd4,
    VAR_SNP     = 3'd5,
    VAR_MNP     = 3'd6,
    VAR_ERROR   = 3'd7
  } var_kind_e;

  // One result item.
  typedef struct packed {
    var_kind_e              kind;
    logic [CoordBits-1:0]   tgt_begin;
    logic [CoordBits-1:0]   tgt_end;
    logic [CoordBits-1:0]   qry_begin;
    logic [CoordBits-1:0]   qry_end;
    logic                   done;
  } res_t;

  // Match-line symbol that a run of the given kind is made of.
  function automatic map_code_e code_of_kind(input var_kind_e kind);
    map_code_e code;
    unique case (kind)
      VAR_REFCALL:     code = MAP_MATCH;
      VAR_INS, VAR_DEL: code = MAP_GAP;
      default:         code = MAP_MISMATCH;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/alignment_column_variant_runs.sv -----
`timescale 1ns / 1ps

// Alignment column variant caller. Each transfer on the slave stream carries one column of a
// pairwise alignment (match-line code, target base, query base, and on the first column of a
// block the start coordinates and the strand). Columns with the same match-line code are
// grouped into runs, and each finished run leaves on the master stream as one transfer with
// its variant kind in tuser, its target and query coordinates in tdata, and tlast set on the
// last result that the block's last column causes. A column is taken in every cycle that the queue
// has room for two (s_axis_tready high): the run state is updated by a single pass of adders and
// comparators per column, and results go into a four-entry queue in front of the master port. A
// column can close two runs (the pending run and the one its last column finishes) and so give
// two results; the queue drains one result per cycle while m_axis_tready is high, so the sustained
// rate is one column per cycle whenever columns average at most one result each. An unknown
// match-line code gives an error result, and the rest of that block is discarded up to and
// including its last column. A first column arriving mid-block abandons any open run silently.
module alignment_column_variant_runs #(
  parameter int unsigned POS_BITS = acvr_pkg::PosBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Column stream. tdata from bit 0 up: map_code[1:0], target_char[9:2], query_char[17:10],
  // first_col[18], target_start[49:19], query_start[80:50], minus_strand[81], zero pad.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [87:0]   s_axis_tdata,
  input  logic          s_axis_tlast,   // last_col
  // Result stream. tdata from bit 0 up: tgt_begin[31:0], tgt_end[63:32],
  // qry_begin[95:64], qry_end[127:96].
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,
  output logic [2:0]    m_axis_tuser,   // var_kind
  output logic          m_axis_tlast    // block_done
);
  import acvr_pkg::*;

  typedef logic [POS_BITS-1:0] pos_t;

  // Unpacked column fields.
  map_code_e            map_code;
  logic [7:0]           target_char;
  logic [7:0]           query_char;
  logic                 first_col;
  logic                 last_col;
  logic [StartBits-1:0] target_start;
  logic [StartBits-1:0] query_start;
  logic                 minus_strand;

  assign map_code     = map_code_e'(s_axis_tdata[1:0]);
  assign target_char  = s_axis_tdata[9:2];
  assign query_char   = s_axis_tdata[17:10];
  assign first_col    = s_axis_tdata[18];
  assign target_start = s_axis_tdata[49:19];
  assign query_start  = s_axis_tdata[80:50];
  assign minus_strand = s_axis_tdata[81];
  assign last_col     = s_axis_tlast;

  // Run state.
  var_kind_e run_kind_q, run_kind_d;
  logic      run_active_q, run_active_d;
  logic      strand_down_q, strand_down_d;
  logic      drop_rest_q, drop_rest_d;
  pos_t      tpos_begin_q, tpos_begin_d;
  pos_t      tpos_end_q, tpos_end_d;
  pos_t      qpos_begin_q, qpos_begin_d;
  pos_t      qpos_end_q, qpos_end_d;

  logic col_fire;
  logic push0, push1;
  res_t res0, res1;
  logic room2;
  res_t out_res;

  assign col_fire      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room2;

  // Positions leave the block as their low coordinate bits, zero-filled when narrower.
  function automatic logic [CoordBits-1:0] to_coord(input pos_t p);
    logic [POS_BITS+CoordBits-1:0] wide;
    wide = {{CoordBits{1'b0}}, p};
    return wide[CoordBits-1:0];
  endfunction

  // Start coordinates wrap into the position width.
  function automatic pos_t from_start(input logic [StartBits-1:0] s);
    logic [POS_BITS+StartBits-1:0] wide;
    wide = {{POS_BITS{1'b0}}, s};
    return wide[POS_BITS-1:0];
  endfunction

  // Result for the run held in the given state; MNP and the ordering of the query ends
  // are settled here.
  function automatic res_t close_res(input var_kind_e kind, input pos_t tb, input pos_t te,
                                     input pos_t qb, input pos_t qe, input logic done);
    res_t r;
    r.kind = kind;
    if (kind == VAR_SNP && $signed(te) > $signed(tb)) begin
      r.kind = VAR_MNP;
    end
    r.tgt_begin = to_coord(tb);
    r.tgt_end   = to_coord(te);
    if ($signed(qe) < $signed(qb)) begin
      r.qry_begin = to_coord(qe);
      r.qry_end   = to_coord(qb);
    end else begin
      r.qry_begin = to_coord(qb);
      r.qry_end   = to_coord(qe);
    end
    r.done = done;
    return r;
  endfunction

  always_comb begin
    pos_t inc;
    logic cont;
    res_t r;

    run_kind_d    = run_kind_q;
    run_active_d  = run_active_q;
    strand_down_d = strand_down_q;
    drop_rest_d   = drop_rest_q;
    tpos_begin_d  = tpos_begin_q;
    tpos_end_d    = tpos_end_q;
    qpos_begin_d  = qpos_begin_q;
    qpos_end_d    = qpos_end_q;
    push0 = 1'b0;
    push1 = 1'b0;
    res0  = '0;
    res1  = '0;
    inc   = '0;
    cont  = 1'b0;
    r     = '0;

    if (col_fire) begin
      if (first_col) begin
        run_active_d  = 1'b0;
        drop_rest_d   = 1'b0;
        strand_down_d = minus_strand;
        tpos_begin_d  = from_start(target_start);
        tpos_end_d    = from_start(target_start);
        qpos_begin_d  = from_start(query_start);
        qpos_end_d    = from_start(query_start);
      end

      if (drop_rest_d) begin
        // Discarding the remainder of a block after an unknown code.
        if (last_col) begin
          drop_rest_d = 1'b0;
        end
      end else begin
        inc  = strand_down_d ? '1 : pos_t'(1);
        cont = run_active_d && map_code != MAP_OTHER &&
               map_code == code_of_kind(run_kind_d);

        // A change of code closes the pending run first.
        if (run_active_d && !cont) begin
          res0  = close_res(run_kind_d, tpos_begin_d, tpos_end_d, qpos_begin_d, qpos_end_d,
                            1'b0);
          push0 = 1'b1;
          tpos_end_d   = tpos_end_d + pos_t'(1);
          qpos_end_d   = qpos_end_d + inc;
          tpos_begin_d = tpos_end_d;
          qpos_begin_d = qpos_end_d;
          run_active_d = 1'b0;
        end

        if (map_code == MAP_OTHER) begin
          r      = '0;
          r.kind = VAR_ERROR;
          r.done = last_col;
          if (!push0) begin
            res0  = r;
            push0 = 1'b1;
          end else begin
            res1  = r;
            push1 = 1'b1;
          end
          if (!last_col) begin
            drop_rest_d = 1'b1;
          end
        end else begin
          if (cont) begin
            if (map_code == MAP_GAP) begin
              // Inside a gap run each side moves only where it holds a base.
              if (target_char != CharGap) begin
                tpos_end_d = tpos_end_d + pos_t'(1);
              end
              if (query_char != CharGap) begin
                qpos_end_d = qpos_end_d + inc;
              end
            end else begin
              tpos_end_d = tpos_end_d + pos_t'(1);
              qpos_end_d = qpos_end_d + inc;
            end
          end else begin
            unique case (map_code)
              MAP_MATCH: begin
                run_kind_d = VAR_REFCALL;
              end
              MAP_GAP: begin
                // Gap runs start one step back on both sides.
                tpos_begin_d = tpos_begin_d - pos_t'(1);
                qpos_begin_d = qpos_begin_d - inc;
                if (target_char == CharGap) begin
                  run_kind_d = VAR_INS;
                  tpos_end_d = tpos_end_d - pos_t'(1);
                end else begin
                  run_kind_d = VAR_DEL;
                  qpos_end_d = qpos_end_d - inc;
                end
              end
              default: begin
                if (target_char == CharNUp || target_char == CharNLow) begin
                  run_kind_d = VAR_NTGT;
                end else if (query_char == CharNUp || query_char == CharNLow) begin
                  run_kind_d = VAR_NQRY;
                end else begin
                  run_kind_d = VAR_SNP;
                end
              end
            endcase
            run_active_d = 1'b1;
          end

          // The block's last column closes whatever run it leaves open.
          if (last_col) begin
            r = close_res(run_kind_d, tpos_begin_d, tpos_end_d, qpos_begin_d, qpos_end_d,
                          1'b1);
            if (!push0) begin
              res0  = r;
              push0 = 1'b1;
            end else begin
              res1  = r;
              push1 = 1'b1;
            end
            tpos_end_d   = tpos_end_d + pos_t'(1);
            qpos_end_d   = qpos_end_d + inc;
            tpos_begin_d = tpos_end_d;
            qpos_begin_d = qpos_end_d;
            run_active_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_kind_q    <= VAR_REFCALL;
      run_active_q  <= 1'b0;
      strand_down_q <= 1'b0;
      drop_rest_q   <= 1'b0;
      tpos_begin_q  <= '0;
      tpos_end_q    <= '0;
      qpos_begin_q  <= '0;
      qpos_end_q    <= '0;
    end else begin
      run_kind_q    <= run_kind_d;
      run_active_q  <= run_active_d;
      strand_down_q <= strand_down_d;
      drop_rest_q   <= drop_rest_d;
      tpos_begin_q  <= tpos_begin_d;
      tpos_end_q    <= tpos_end_d;
      qpos_begin_q  <= qpos_begin_d;
      qpos_end_q    <= qpos_end_d;
    end
  end

  acvr_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push0_i  (push0),
    .push1_i  (push1),
    .wdata0_i (res0),
    .wdata1_i (res1),
    .room2_o  (room2),
    .valid_o  (m_axis_tvalid),
    .pop_i    (m_axis_tready),
    .rdata_o  (out_res)
  );

  assign m_axis_tdata = {out_res.qry_end, out_res.qry_begin, out_res.tgt_end, out_res.tgt_begin};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.done;

endmodule

// ----- hw/rtl/acvr_res_fifo.sv -----
`timescale 1ns / 1ps

// Small result queue: up to two writes per cycle, one read per cycle.
module acvr_res_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push0_i,
  input  logic          push1_i,
  input  acvr_pkg::res_t wdata0_i,
  input  acvr_pkg::res_t wdata1_i,
  output logic          room2_o,
  output logic          valid_o,
  input  logic          pop_i,
  output acvr_pkg::res_t rdata_o
);
  import acvr_pkg::*;

  res_t                  mem_q [ResDepth];
  logic [ResPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [ResPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [ResCntBits-1:0] count_q, count_d;
  logic                  do_pop;
  logic [ResPtrBits-1:0] wr_ptr_nx;

  assign valid_o   = (count_q != '0);
  assign rdata_o   = mem_q[rd_ptr_q];
  assign do_pop    = pop_i && valid_o;
  assign room2_o   = (count_q <= ResCntBits'(ResDepth - 2));
  assign wr_ptr_nx = wr_ptr_q + ResPtrBits'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (push0_i) begin
      wr_ptr_d = wr_ptr_d + ResPtrBits'(1);
      count_d  = count_d + ResCntBits'(1);
    end
    if (push1_i) begin
      wr_ptr_d = wr_ptr_d + ResPtrBits'(1);
      count_d  = count_d + ResCntBits'(1);
    end
    rd_ptr_d = rd_ptr_q;
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + ResPtrBits'(1);
      count_d  = count_d - ResCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage needs no reset. The second write only ever follows a first one.
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= wdata0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_nx] <= wdata1_i;
    end
  end

endmodule
